// ===== design/isd_pkg.sv =====
package isd_pkg;

    localparam int VALUE_BITS_DEF = 31;
    localparam int N_FIELDS       = 7;
    localparam int FIELD_IDX_W    = $clog2(N_FIELDS);

    // ASCII characters that the grammar knows
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_Y     = 8'h59;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_S     = 8'h53;

    // token kinds produced by the classifier
    localparam logic [3:0] TK_DIGIT = 4'd0;
    localparam logic [3:0] TK_MINUS = 4'd1;
    localparam logic [3:0] TK_P     = 4'd2;
    localparam logic [3:0] TK_Y     = 4'd3;
    localparam logic [3:0] TK_M     = 4'd4;
    localparam logic [3:0] TK_D     = 4'd5;
    localparam logic [3:0] TK_T     = 4'd6;
    localparam logic [3:0] TK_H     = 4'd7;
    localparam logic [3:0] TK_DOT   = 4'd8;
    localparam logic [3:0] TK_S     = 4'd9;
    localparam logic [3:0] TK_OTHER = 4'd10;

    // error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_NO_P    = 2'd1;
    localparam logic [1:0] ERR_BAD_DES = 2'd2;
    localparam logic [1:0] ERR_NO_S    = 2'd3;

    // field slots
    localparam logic [FIELD_IDX_W-1:0] F_YEARS    = 3'd0;
    localparam logic [FIELD_IDX_W-1:0] F_MONTHS   = 3'd1;
    localparam logic [FIELD_IDX_W-1:0] F_DAYS     = 3'd2;
    localparam logic [FIELD_IDX_W-1:0] F_HOURS    = 3'd3;
    localparam logic [FIELD_IDX_W-1:0] F_MINUTES  = 3'd4;
    localparam logic [FIELD_IDX_W-1:0] F_SECONDS  = 3'd5;
    localparam logic [FIELD_IDX_W-1:0] F_FRACTION = 3'd6;

    typedef struct packed {
        logic [3:0] kind;
        logic [3:0] digit;
        logic       last;
    } isd_token_t;

endpackage

// ===== design/isd_if.sv =====
interface isd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface isd_result_if #(parameter int VALUE_BITS = 31);
    logic                  valid;
    logic                  ready;
    logic [1:0]            error_code;
    logic                  negative;
    logic [VALUE_BITS-1:0] years;
    logic [VALUE_BITS-1:0] months;
    logic [VALUE_BITS-1:0] days;
    logic [VALUE_BITS-1:0] hours;
    logic [VALUE_BITS-1:0] minutes;
    logic [VALUE_BITS-1:0] seconds;
    logic [VALUE_BITS-1:0] fraction_digits;

    modport source (output valid, output error_code, output negative, output years,
                    output months, output days, output hours, output minutes,
                    output seconds, output fraction_digits, input ready);
    modport sink   (input valid, input error_code, input negative, input years,
                    input months, input days, input hours, input minutes,
                    input seconds, input fraction_digits, output ready);
endinterface

// ===== design/iso_duration_string_parser.sv =====
// Path: a last byte goes through the token queue and then the output register, where its result shows valid.
// Throughput: one byte per cycle, set by the parse step in the back end;
//   a last byte waits only while the previous result sits untaken in the output register.
// Reset (rst_n low, asynchronous): queue emptied, parse state and field values cleared,
//   no result pending. Parse state and field values are also cleared after every last byte.
module iso_duration_string_parser
    import isd_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    isd_byte_if.sink      chars,
    isd_result_if.source  result
);

    // Front end: each byte transaction is classified into a token (digit value or
    // designator kind plus the last flag) and pushed into a two-entry queue.
    // Back end: pops one token per cycle, holding a last token while an untaken result
    // fills the output register, and runs the parse state machine, saturating the digit
    // accumulator and storing it at designators. The last token loads the output register,
    // which frees the back end to go on with the next string while the result waits to be taken.

    logic       tok_valid;
    logic       tok_ready;
    isd_token_t tok;

    isd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok       (tok)
    );

    isd_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok       (tok),
        .result    (result)
    );

endmodule

// ===== design/isd_front.sv =====
module isd_front
    import isd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    isd_byte_if.sink      chars,
    output logic          tok_valid,
    input  logic          tok_ready,
    output isd_token_t    tok
);

    function automatic isd_token_t classify(input logic [7:0] c, input logic last);
        isd_token_t t;
        t.kind  = TK_OTHER;
        t.digit = 4'd0;
        t.last  = last;
        if (c inside {[CH_ZERO:CH_NINE]})
        begin
            t.kind  = TK_DIGIT;
            t.digit = 4'(c - CH_ZERO);
        end
        else
        begin
            case (c)
                CH_MINUS: t.kind = TK_MINUS;
                CH_P:     t.kind = TK_P;
                CH_Y:     t.kind = TK_Y;
                CH_M:     t.kind = TK_M;
                CH_D:     t.kind = TK_D;
                CH_T:     t.kind = TK_T;
                CH_H:     t.kind = TK_H;
                CH_DOT:   t.kind = TK_DOT;
                CH_S:     t.kind = TK_S;
                default:  t.kind = TK_OTHER;
            endcase
        end
        return t;
    endfunction

    // two-entry token queue
    isd_token_t  mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push, pop;

    assign chars.ready = (count_reg != 2'd2);
    assign push        = chars.valid && chars.ready;
    assign tok_valid   = (count_reg != 2'd0);
    assign pop         = tok_valid && tok_ready;
    assign tok         = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= classify(chars.char_code, chars.is_last);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/isd_back.sv =====
module isd_back
    import isd_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          tok_valid,
    output logic          tok_ready,
    input  isd_token_t    tok,
    isd_result_if.source  result
);

    localparam logic [1:0] PH_START  = 2'd0;
    localparam logic [1:0] PH_WANT_P = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;
    localparam logic [1:0] PH_ERROR  = 2'd3;
    localparam int         PW        = VALUE_BITS + 4;
    localparam logic [PW-1:0] VMAX_W = {4'd0, {VALUE_BITS{1'b1}}};

    logic [1:0]            phase_reg, phase_next;
    logic                  tmark_reg, tmark_next;
    logic                  frac_reg, frac_next;
    logic                  sign_reg, sign_next;
    logic [1:0]            err_reg, err_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic [VALUE_BITS-1:0] field_reg  [N_FIELDS];
    logic [VALUE_BITS-1:0] field_next [N_FIELDS];

    logic                  out_valid_reg;
    logic [1:0]            out_err_reg;
    logic                  out_neg_reg;
    logic [VALUE_BITS-1:0] out_field_reg [N_FIELDS];

    logic                  pop, load;
    logic [PW-1:0]         prod;
    logic [VALUE_BITS-1:0] acc_dig;
    logic                  store_en;
    logic [FIELD_IDX_W-1:0] store_idx;
    logic [1:0]            fin_err;

    // a non-last token never needs the output slot
    assign tok_ready = !tok.last || !out_valid_reg || result.ready;
    assign pop       = tok_valid && tok_ready;
    assign load      = pop && tok.last;

    // saturating acc*10 + d
    always_comb
    begin
        prod    = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) + PW'(tok.digit);
        acc_dig = (prod > VMAX_W) ? {VALUE_BITS{1'b1}} : prod[VALUE_BITS-1:0];
    end

    always_comb
    begin
        phase_next = phase_reg;
        tmark_next = tmark_reg;
        frac_next  = frac_reg;
        sign_next  = sign_reg;
        err_next   = err_reg;
        acc_next   = acc_reg;
        store_en   = 1'b0;
        store_idx  = F_YEARS;
        fin_err    = ERR_NONE;
        field_next = field_reg;

        if (pop)
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (tok.kind == TK_MINUS)
                    begin
                        sign_next  = 1'b1;
                        phase_next = PH_WANT_P;
                    end
                    else if (tok.kind == TK_P)
                        phase_next = PH_BODY;
                    else
                    begin
                        err_next   = ERR_NO_P;
                        phase_next = PH_ERROR;
                    end
                end
                PH_WANT_P:
                begin
                    if (tok.kind == TK_P)
                        phase_next = PH_BODY;
                    else
                    begin
                        err_next   = ERR_NO_P;
                        phase_next = PH_ERROR;
                    end
                end
                PH_BODY:
                begin
                    if (tok.kind == TK_DIGIT)
                        acc_next = acc_dig;
                    else if (frac_reg)
                    begin
                        if (tok.kind == TK_S)
                        begin
                            store_en  = 1'b1;
                            store_idx = F_FRACTION;
                            frac_next = 1'b0;
                        end
                        else
                        begin
                            err_next   = ERR_NO_S;
                            phase_next = PH_ERROR;
                        end
                    end
                    else if (!tmark_reg)
                    begin
                        case (tok.kind)
                            TK_Y:
                            begin
                                store_en  = 1'b1;
                                store_idx = F_YEARS;
                            end
                            TK_M:
                            begin
                                store_en  = 1'b1;
                                store_idx = F_MONTHS;
                            end
                            TK_D:
                            begin
                                store_en  = 1'b1;
                                store_idx = F_DAYS;
                            end
                            TK_T:
                            begin
                                acc_next   = '0;
                                tmark_next = 1'b1;
                            end
                            default:
                            begin
                                err_next   = ERR_BAD_DES;
                                phase_next = PH_ERROR;
                            end
                        endcase
                    end
                    else
                    begin
                        case (tok.kind)
                            TK_H:
                            begin
                                store_en  = 1'b1;
                                store_idx = F_HOURS;
                            end
                            TK_M:
                            begin
                                store_en  = 1'b1;
                                store_idx = F_MINUTES;
                            end
                            TK_S:
                            begin
                                store_en  = 1'b1;
                                store_idx = F_SECONDS;
                            end
                            TK_DOT:
                            begin
                                store_en  = 1'b1;
                                store_idx = F_SECONDS;
                                frac_next = 1'b1;
                            end
                            default:
                            begin
                                err_next   = ERR_BAD_DES;
                                phase_next = PH_ERROR;
                            end
                        endcase
                    end
                end
                default: ;
            endcase

            if (store_en)
            begin
                field_next[store_idx] = acc_reg;
                acc_next              = '0;
            end

            // end-of-string checks
            if (phase_next == PH_START || phase_next == PH_WANT_P)
                fin_err = ERR_NO_P;
            else if (phase_next == PH_BODY && frac_next)
                fin_err = ERR_NO_S;
            else if (phase_next == PH_ERROR)
                fin_err = err_next;
            else
                fin_err = ERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            tmark_reg     <= 1'b0;
            frac_reg      <= 1'b0;
            sign_reg      <= 1'b0;
            err_reg       <= ERR_NONE;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < N_FIELDS; i++)
            begin
                field_reg[i] <= '0;
            end
        end
        else
        begin
            if (load)
            begin
                // string done: back to the reset state
                phase_reg <= PH_START;
                tmark_reg <= 1'b0;
                frac_reg  <= 1'b0;
                sign_reg  <= 1'b0;
                err_reg   <= ERR_NONE;
                acc_reg   <= '0;
                for (int i = 0; i < N_FIELDS; i++)
                begin
                    field_reg[i] <= '0;
                end
            end
            else
            begin
                phase_reg <= phase_next;
                tmark_reg <= tmark_next;
                frac_reg  <= frac_next;
                sign_reg  <= sign_next;
                err_reg   <= err_next;
                acc_reg   <= acc_next;
                field_reg <= field_next;
            end

            if (load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_err_reg <= fin_err;
            out_neg_reg <= (fin_err == ERR_NONE) ? sign_next : 1'b0;
            for (int i = 0; i < N_FIELDS; i++)
            begin
                out_field_reg[i] <= (fin_err == ERR_NONE) ? field_next[i] : '0;
            end
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.error_code      = out_err_reg;
    assign result.negative        = out_neg_reg;
    assign result.years           = out_field_reg[F_YEARS];
    assign result.months          = out_field_reg[F_MONTHS];
    assign result.days            = out_field_reg[F_DAYS];
    assign result.hours           = out_field_reg[F_HOURS];
    assign result.minutes         = out_field_reg[F_MINUTES];
    assign result.seconds         = out_field_reg[F_SECONDS];
    assign result.fraction_digits = out_field_reg[F_FRACTION];

endmodule

// ===== verif/isd_duration_checker.sv =====
module isd_duration_checker
    import isd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    isd_byte_if         chars,
    isd_result_if       result,
    output int unsigned fails,
    output int unsigned pending,
    output int unsigned checked,
    output int unsigned error_reports
);

    localparam int VB = VALUE_BITS_DEF;
    localparam logic [VB-1:0] FIELD_MAX = '1;

    typedef enum logic [1:0] {
        ST_LEAD,
        ST_NEED_P,
        ST_BODY,
        ST_FAILED
    } parse_state_e;

    typedef struct packed {
        logic [1:0]                   code;
        logic                         neg;
        logic [N_FIELDS-1:0][VB-1:0]  vals;
    } duration_t;

    duration_t    durations_due[$];

    parse_state_e st;
    logic         time_part;
    logic         frac_open;
    logic         minus_seen;
    logic [1:0]   err_latched;
    logic [VB-1:0] acc;
    logic [VB-1:0] vals [N_FIELDS];

    int unsigned  fail_cnt   = 0;
    int unsigned  check_cnt  = 0;
    int unsigned  err_cnt    = 0;
    int unsigned  due_cnt    = 0;

    string field_name [N_FIELDS] = '{"years", "months", "days", "hours",
                                      "minutes", "seconds", "fraction_digits"};

    assign fails         = fail_cnt;
    assign pending       = due_cnt;
    assign checked       = check_cnt;
    assign error_reports = err_cnt;

    function automatic void clear_parse();
        st          = ST_LEAD;
        time_part   = 1'b0;
        frac_open   = 1'b0;
        minus_seen  = 1'b0;
        err_latched = ERR_NONE;
        acc         = '0;
        for (int i = 0; i < N_FIELDS; i++)
            vals[i] = '0;
    endfunction

    function automatic void fail_with(input logic [1:0] code);
        err_latched = code;
        st          = ST_FAILED;
    endfunction

    function automatic void set_field(input int idx);
        vals[idx] = acc;
        acc       = '0;
    endfunction

    function automatic void take_body(input logic [7:0] c);
        logic [VB-1:0] d;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = VB'(c - CH_ZERO);
            if (acc > (FIELD_MAX - d) / 10)
                acc = FIELD_MAX;
            else
                acc = VB'(acc * 10 + d);
        end
        else if (frac_open) begin
            if (c == CH_S) begin
                set_field(F_FRACTION);
                frac_open = 1'b0;
            end
            else
                fail_with(ERR_NO_S);
        end
        else if (!time_part) begin
            case (c)
                CH_Y:    set_field(F_YEARS);
                CH_M:    set_field(F_MONTHS);
                CH_D:    set_field(F_DAYS);
                CH_T:
                begin
                    acc       = '0;
                    time_part = 1'b1;
                end
                default: fail_with(ERR_BAD_DES);
            endcase
        end
        else begin
            case (c)
                CH_H:    set_field(F_HOURS);
                CH_M:    set_field(F_MINUTES);
                CH_S:    set_field(F_SECONDS);
                CH_DOT:
                begin
                    set_field(F_SECONDS);
                    frac_open = 1'b1;
                end
                default: fail_with(ERR_BAD_DES);
            endcase
        end
    endfunction

    // one accepted byte; a last byte queues the duration it closes
    function automatic void parse_byte(input logic [7:0] c, input logic last);
        duration_t d;
        case (st)
            ST_LEAD:
            begin
                if (c == CH_MINUS) begin
                    minus_seen = 1'b1;
                    st         = ST_NEED_P;
                end
                else if (c == CH_P)
                    st = ST_BODY;
                else
                    fail_with(ERR_NO_P);
            end
            ST_NEED_P:
            begin
                if (c == CH_P)
                    st = ST_BODY;
                else
                    fail_with(ERR_NO_P);
            end
            ST_BODY:   take_body(c);
            default:   ;
        endcase
        if (last) begin
            if (st == ST_LEAD || st == ST_NEED_P)
                fail_with(ERR_NO_P);
            else if (st == ST_BODY && frac_open)
                fail_with(ERR_NO_S);
            d = '0;
            if (st == ST_FAILED)
                d.code = err_latched;
            else begin
                d.code = ERR_NONE;
                d.neg  = minus_seen;
                for (int i = 0; i < N_FIELDS; i++)
                    d.vals[i] = vals[i];
            end
            durations_due.push_back(d);
            clear_parse();
        end
    endfunction

    function automatic void flag_mismatch(input string what, input longint unsigned want,
                                          input longint unsigned got);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        fail_cnt++;
    endfunction

    function automatic void check_duration();
        duration_t     want;
        logic [VB-1:0] got [N_FIELDS];
        got[F_YEARS]    = result.years;
        got[F_MONTHS]   = result.months;
        got[F_DAYS]     = result.days;
        got[F_HOURS]    = result.hours;
        got[F_MINUTES]  = result.minutes;
        got[F_SECONDS]  = result.seconds;
        got[F_FRACTION] = result.fraction_digits;
        if (durations_due.size() == 0) begin
            $display("%0t: unexpected result transaction, error_code %0d",
                     $time, result.error_code);
            fail_cnt++;
            return;
        end
        want = durations_due.pop_front();
        check_cnt++;
        if (want.code != ERR_NONE)
            err_cnt++;
        if (result.error_code !== want.code)
            flag_mismatch("error_code", want.code, result.error_code);
        if (result.negative !== want.neg)
            flag_mismatch("negative", want.neg, result.negative);
        for (int i = 0; i < N_FIELDS; i++)
            if (got[i] !== want.vals[i])
                flag_mismatch(field_name[i], want.vals[i], got[i]);
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            clear_parse();
            durations_due.delete();
        end
        else begin
            if (result.valid && result.ready)
                check_duration();
            if (chars.valid && chars.ready)
                parse_byte(chars.char_code, chars.is_last);
        end
        due_cnt = durations_due.size();
    end

endmodule

// ===== verif/tb_top.sv =====
// Testbench for iso_duration_string_parser.
// Duration strings are streamed in one byte per transaction; the checker next to
// the parser predicts each result and compares it field by field. This module
// only makes stimulus, handles the result side's ready and gives the verdict.
module tb_top
    import isd_pkg::*;
();

    localparam int HOLD_CYCLES = 80;     // long result-side hold-off
    localparam int QUIET_LIMIT = 2000;   // cycles with no transaction before giving up
    localparam int RAND_BYTES  = 360;

    // characters that matter to the grammar, used to corrupt strings plausibly
    localparam logic [7:0] PARSER_CHARS [10] = '{CH_MINUS, CH_P, CH_Y, CH_M, CH_D,
                                                 CH_T, CH_H, CH_DOT, CH_S, CH_ZERO};

    logic clk;
    logic rst_n;

    isd_byte_if                                  chars();
    isd_result_if #(.VALUE_BITS(VALUE_BITS_DEF)) result();

    int unsigned fails;
    int unsigned pending;
    int unsigned checked;
    int unsigned error_reports;

    int          src_idle_pct  = 14;
    int          sink_idle_pct = 14;
    bit          stall_req     = 1'b0;
    int unsigned bytes_sent    = 0;
    int unsigned strings_sent  = 0;
    int unsigned quiet_cycles  = 0;

    logic [7:0]  draft[$];   // string under construction

    iso_duration_string_parser #(.VALUE_BITS(VALUE_BITS_DEF)) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars),
        .result (result)
    );

    isd_duration_checker u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .chars         (chars),
        .result        (result),
        .fails         (fails),
        .pending       (pending),
        .checked       (checked),
        .error_reports (error_reports)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result side: random back-pressure. A stall request holds ready low for a
    // long stretch so the output register fills and the parser stalls its input.
    initial
    begin
        result.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_req)
            begin
                stall_req    = 1'b0;
                result.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            result.ready = ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Watchdog: any transaction on either side resets the count.
    always @(posedge clk)
    begin
        if (!rst_n || (chars.valid && chars.ready) || (result.valid && result.ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Offer one byte from the falling edge on, with random gaps in front,
    // and return once it has been taken at a rising edge.
    task automatic put_byte(input logic [7:0] c, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            chars.valid = 1'b0;
            @(negedge clk);
        end
        chars.valid     = 1'b1;
        chars.char_code = c;
        chars.is_last   = last;
        @(posedge clk);
        while (!chars.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_draft();
        for (int i = 0; i < draft.size(); i++)
            put_byte(draft[i], i == draft.size() - 1);
        strings_sent++;
    endtask

    task automatic send_text(input string s);
        draft.delete();
        for (int i = 0; i < s.len(); i++)
            draft.push_back(s[i]);
        send_draft();
    endtask

    // Mostly short runs; now and then none at all, or long runs that may saturate.
    task automatic add_digits();
        int r;
        int n;
        r = $urandom_range(19);
        if (r < 2)
            n = 0;
        else if (r < 17)
            n = $urandom_range(4, 1);
        else
            n = $urandom_range(12, 9);
        repeat (n)
            draft.push_back(CH_ZERO + 8'($urandom_range(9)));
    endtask

    // Well-formed duration with random content and random choice of parts.
    task automatic build_duration();
        logic [7:0] date_des [3];
        date_des = '{CH_Y, CH_M, CH_D};
        draft.delete();
        if ($urandom_range(1))
            draft.push_back(CH_MINUS);
        draft.push_back(CH_P);
        foreach (date_des[i])
            if ($urandom_range(99) < 55)
            begin
                add_digits();
                draft.push_back(date_des[i]);
            end
        // extra date designator, possibly repeated: later value overwrites
        if ($urandom_range(9) == 0)
        begin
            add_digits();
            draft.push_back(date_des[$urandom_range(2)]);
        end
        if ($urandom_range(99) < 60)
        begin
            draft.push_back(CH_T);
            if ($urandom_range(1))
            begin
                add_digits();
                draft.push_back(CH_H);
            end
            if ($urandom_range(1))
            begin
                add_digits();
                draft.push_back(CH_M);
            end
            if ($urandom_range(1))
            begin
                add_digits();
                if ($urandom_range(2) == 0)
                begin
                    draft.push_back(CH_DOT);
                    add_digits();
                end
                draft.push_back(CH_S);
            end
        end
        // trailing digits with no designator are dropped by the parser
        if ($urandom_range(4) == 0)
            add_digits();
    endtask

    // Break a string: swap in a grammar char or any byte, cut it short,
    // or throw it away for plain noise.
    task automatic mangle_duration();
        case ($urandom_range(3))
            0:       draft[$urandom_range(draft.size() - 1)] = PARSER_CHARS[$urandom_range(9)];
            1:       draft[$urandom_range(draft.size() - 1)] = 8'($urandom);
            2:       draft = draft[0:$urandom_range(draft.size() - 1)];
            default:
            begin
                draft.delete();
                repeat ($urandom_range(6, 1))
                    draft.push_back(8'($urandom));
            end
        endcase
    endtask

    task automatic random_burst(input int n);
        int unsigned stop_at;
        stop_at = bytes_sent + n;
        while (bytes_sent < stop_at)
        begin
            build_duration();
            if ($urandom_range(3) == 0)
                mangle_duration();
            send_draft();
        end
    endtask

    // hold new strings back until every result is in
    task automatic wait_drained();
        @(negedge clk);
        chars.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        chars.valid     = 1'b0;
        chars.char_code = '0;
        chars.is_last   = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ---- directed ----
        send_text("P");                              // empty body
        send_text("-P1Y2M3DT4H5M6.789S");            // every field, negative
        send_text("X");                              // missing P
        send_text("-");                              // ends before P
        send_text("-Q5D");                           // minus then no P
        send_text("PZ12Y");                          // error latched, rest ignored
        send_text("P1H");                            // time letter in date part
        send_text("PT1D");                           // date letter in time part
        send_text("P1.5S");                          // point before T
        send_text("PT1H2T");                         // second T
        send_text("PT1.5X");                         // fraction not closed by S
        send_text("PT1.5");                          // string ends inside fraction
        send_text("PT.S");                           // empty whole and fraction runs
        send_text("P2147483647Y2147483648D99999999999M"); // field max and saturation
        send_text("P1D22");                          // trailing digits
        send_text("PYMDTHMS");                       // designators with no digits
        send_text("P1Y2Y");                          // repeated designator
        draft = '{8'h00};
        send_draft();
        draft = '{CH_P, 8'hFF};
        send_draft();
        wait_drained();

        // ---- random ----
        random_burst(RAND_BYTES * 3 / 10);

        // stretch with no idling on either side
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        random_burst(RAND_BYTES / 5);
        src_idle_pct  = 14;
        sink_idle_pct = 14;

        // receiver holds off while strings keep coming
        stall_req = 1'b1;
        random_burst(RAND_BYTES / 8);
        wait_drained();

        random_burst(RAND_BYTES * 3 / 8);
        wait_drained();

        // idle on to catch any stray result
        repeat (10) @(negedge clk);

        $display("summary: %0d strings in %0d bytes, %0d results compared",
                 strings_sent, bytes_sent, checked);
        $display("summary: %0d of the results were parse error reports", error_reports);
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
